FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define MF3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MF3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    `MF3_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MF3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    `MF3_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/mf3_pkg.sv
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

    typedef logic [7:0] t_pix;
    typedef t_pix [8:0] t_taps;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       flush;
    } t_in_item;

    typedef struct packed {
        logic [7:0] median_value;
        logic       end_of_frame;
    } t_out_item;

    typedef struct packed {
        t_pix lo;
        t_pix mid;
        t_pix hi;
    } t_trio;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_trio sort3(input t_pix a, input t_pix b, input t_pix c);
        t_pix  lo;
        t_pix  hi;
        t_trio res;
        lo = min2(a, b);
        hi = max2(a, b);
        if (c < lo) begin
            res = '{lo: c, mid: lo, hi: hi};
        end else if (c > hi) begin
            res = '{lo: lo, mid: hi, hi: c};
        end else begin
            res = '{lo: lo, mid: c, hi: hi};
        end
        return res;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

FILE: rtl/core/mf3_median.sv
module mf3_median (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mf3_pkg::t_taps      i_taps,
    input  logic                i_eof,
    output logic                o_valid,
    input  logic                i_stall,
    output mf3_pkg::t_out_item  o_item
);
    import mf3_pkg::*;

    logic      r_t_v;
    t_taps     r_taps;
    logic      r_t_eof;
    logic      r_a_v;
    t_trio     r_rows [3];
    logic      r_a_eof;
    logic      r_b_v;
    t_trio     r_mix;
    logic      r_b_eof;
    logic      r_c_v;
    t_out_item r_out;

    logic free_c;
    logic free_b;
    logic free_a;
    logic free_t;

    assign free_c  = !r_c_v || !i_stall;
    assign free_b  = !r_b_v || free_c;
    assign free_a  = !r_a_v || free_b;
    assign free_t  = !r_t_v || free_a;
    assign o_stall = !free_t;
    assign o_valid = r_c_v;
    assign o_item  = r_out;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (free_t) r_t_v <= i_valid;
            if (free_a) r_a_v <= r_t_v;
            if (free_b) r_b_v <= r_a_v;
            if (free_c) r_c_v <= r_b_v;
        end
    end

    // taps -> sorted rows -> max/med/min -> median
    always_ff @(posedge i_clk) begin
        if (free_t) begin
            r_taps  <= i_taps;
            r_t_eof <= i_eof;
        end
        if (free_a) begin
            for (int k = 0; k < 3; k++) begin
                r_rows[k] <= sort3(r_taps[3*k], r_taps[3*k+1], r_taps[3*k+2]);
            end
            r_a_eof <= r_t_eof;
        end
        if (free_b) begin
            r_mix.lo  <= max2(max2(r_rows[0].lo, r_rows[1].lo), r_rows[2].lo);
            r_mix.mid <= med3(r_rows[0].mid, r_rows[1].mid, r_rows[2].mid);
            r_mix.hi  <= min2(min2(r_rows[0].hi, r_rows[1].hi), r_rows[2].hi);
            r_b_eof   <= r_a_eof;
        end
        if (free_c) begin
            r_out.median_value <= med3(r_mix.lo, r_mix.mid, r_mix.hi);
            r_out.end_of_frame <= r_b_eof;
        end
    end

endmodule

FILE: rtl/core/median_filter_3x3.sv
// 3x3 median filter, 8-bit grayscale, replicated borders.
// Input channel: i_in_valid / o_in_stall with i_in_item (pixel, flush), raster order.
// Output channel: o_out_valid / i_out_stall with o_out_item (median, end_of_frame).
// An item moves when valid is high and stall is low at a rising edge.
// Each result is the median for the pixel one line and one pixel behind the input;
// it is registered in stage 1 and then in the sorter's taps, rows, mix and output stages.
// After the last pixel, clamped frame_width + 1 more items (flush or not) drain the rest;
// end_of_frame marks the last result, and the next item starts a new frame.
// A flush item before the last pixel is taken and ignored.
// Throughput: one item per cycle when not stalled; one dual-port line memory (one read,
// one write per cycle, {upper, middle} lines per entry) and a 4-stage sorter set the
// latency. A stall from the receiver holds the sorter stages; new items keep entering
// until every stage is full, then o_in_stall follows.
// Config: i_cfg_we writes register i_cfg_idx (0 frame_width, 1 frame_height) and
// restarts the frame; write only while idle.
// Reset: frame 640x480, position zero, window zero; the line memory is not cleared.
module median_filter_3x3 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mf3_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mf3_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mf3_pkg::*;

    `include "assert_macros.svh"

    typedef struct packed {
        logic out_en;
        logic top;
        logic bot;
        logic left;
        logic right;
        logic eof;
    } t_flags;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              in_range;
        t_pix              pix;
        t_flags            flags;
    } t_s1;

    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;
    logic                r_v1;
    t_s1                 r_s1;
    t_pix                r_win [3][3];
    t_pix                n_win [3][3];
    logic [15:0]         r_mem [MAX_WIDTH];
    logic [15:0]         r_rd;

    logic [COL_W-1:0]  w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic              w_draining;
    logic              w_ignore;
    logic              w_accept;
    logic              w_ld1;
    logic              w_in_range0;
    logic              w_col_zero;
    t_flags            w_flags0;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_mem_we;
    logic              w_mv1;
    logic              w_free1;
    logic              w_med_valid;
    logic              w_med_stall;
    logic              w_cfg_hit;
    t_pix              w_col [3];
    t_taps             w_taps;

    // effective frame size
    always_comb begin
        if (r_frame_width < WIDTH_W'(3)) begin
            w_eff = COL_W'(3);
        end else if (r_frame_width > MAX_WIDTH) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(r_frame_width);
        end
        h_eff = (r_frame_height < HEIGHT_W'(3)) ? ROW_W'(3) : ROW_W'(r_frame_height);
    end

    // input position and window centre
    assign w_draining  = r_row >= h_eff;
    assign w_ignore    = i_in_item.flush && !w_draining;
    assign w_free1     = !r_v1 || w_mv1;
    assign o_in_stall  = !w_free1;
    assign w_accept    = i_in_valid && w_free1;
    assign w_ld1       = w_accept && !w_ignore;
    assign w_in_range0 = r_col < w_eff;
    assign w_col_zero  = r_col == '0;
    assign w_rd_en     = w_ld1 && w_in_range0;
    assign w_rd_addr   = r_col[ADDR_W-1:0];

    always_comb begin
        w_flags0.out_en = w_col_zero ? (r_row >= ROW_W'(2)) : (r_row >= ROW_W'(1));
        w_flags0.top    = w_col_zero ? (r_row == ROW_W'(2)) : (r_row == ROW_W'(1));
        w_flags0.bot    = !w_col_zero && (r_row == h_eff);
        w_flags0.left   = r_col == COL_W'(1);
        w_flags0.right  = w_col_zero || (r_col == w_eff);
        w_flags0.eof    = (r_col == w_eff) && (r_row == h_eff);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_flags0.eof) begin
            n_col = '0;
            n_row = '0;
        end else if (w_draining) begin
            n_col = r_col + COL_W'(1);
        end else if (r_col + COL_W'(1) >= w_eff) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_comb begin
        unique case (i_cfg_idx)
            CFG_FRAME_WIDTH:  w_cfg_hit = 1'b1;
            CFG_FRAME_HEIGHT: w_cfg_hit = 1'b1;
            default:          w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
            if (w_cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end
        end else if (w_ld1) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line memory read data available
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_free1) begin
            r_v1 <= w_ld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1.addr     <= w_rd_addr;
            r_s1.in_range <= w_in_range0;
            r_s1.pix      <= w_draining ? '0 : i_in_item.pixel_value;
            r_s1.flags    <= w_flags0;
        end
    end

    // line memory: [15:8] two lines up, [7:0] one line up
    assign w_mem_we = w_mv1 && r_s1.in_range;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_s1.addr] <= {r_rd[7:0], r_s1.pix};
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // window shift and border replication
    assign w_col[0] = r_s1.in_range ? r_rd[15:8] : '0;
    assign w_col[1] = r_s1.in_range ? r_rd[7:0]  : '0;
    assign w_col[2] = r_s1.in_range ? r_s1.pix   : '0;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
            n_win[k][2] = w_col[k];
        end
    end

    always_comb begin
        for (int rr = 0; rr < 3; rr++) begin
            for (int cc = 0; cc < 3; cc++) begin
                w_taps[rr*3+cc] = n_win[rr][cc];
                if ((rr == 0 && r_s1.flags.top) || (rr == 2 && r_s1.flags.bot)) begin
                    if ((cc == 0 && r_s1.flags.left) || (cc == 2 && r_s1.flags.right)) begin
                        w_taps[rr*3+cc] = n_win[1][1];
                    end else begin
                        w_taps[rr*3+cc] = n_win[1][cc];
                    end
                end else if ((cc == 0 && r_s1.flags.left) || (cc == 2 && r_s1.flags.right)) begin
                    w_taps[rr*3+cc] = n_win[rr][1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (w_mv1) begin
            r_win <= n_win;
        end
    end

    assign w_med_valid = r_v1 && r_s1.flags.out_en;
    assign w_mv1       = r_v1 && (!r_s1.flags.out_en || !w_med_stall);

    mf3_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_med_valid),
        .o_stall (w_med_stall),
        .i_taps  (w_taps),
        .i_eof   (r_s1.flags.eof),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    `MF3_ASSERT_IMP(a_mem_no_overlap, i_clk, i_rst_n, w_mem_we && w_rd_en, r_s1.addr != w_rd_addr, "line memory read and write hit the same entry")
    `MF3_ASSERT(a_col_in_bounds, i_clk, i_rst_n, r_col <= w_eff, "input column past frame width")
    `MF3_ASSERT_NXT(a_eof_restart, i_clk, i_rst_n, w_ld1 && w_flags0.eof && !i_cfg_we, r_col == '0 && r_row == '0, "frame did not restart after last result")
    `MF3_ASSERT_NXT(a_flush_ignored, i_clk, i_rst_n, w_accept && w_ignore && !i_cfg_we, $stable(r_col) && $stable(r_row), "ignored flush moved the position")

endmodule

FILE: sim/mf3_median_checker.sv
module mf3_median_checker
    import mf3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HEIGHT = 4095;

    logic [7:0]          upper_line  [MAX_WIDTH];
    logic [7:0]          middle_line [MAX_WIDTH];
    logic [7:0]          win [3][3];
    int unsigned         in_col;
    int unsigned         in_row;
    int unsigned         out_count;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    t_out_item           median_q [$];
    int                  fail_total = 0;

    function automatic logic [7:0] median_of(input logic [8:0][7:0] v);
        logic [7:0] t;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8 - i; j++) begin
                if (v[j] > v[j+1]) begin
                    t      = v[j];
                    v[j]   = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        return v[4];
    endfunction

    function automatic void restart_frame();
        in_col    = 0;
        in_row    = 0;
        out_count = 0;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = 8'h00;
            middle_line[i] = 8'h00;
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                win[k][j] = 8'h00;
            end
        end
        restart_frame();
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
    endfunction

    function automatic void predict_item(input t_in_item it);
        int unsigned     w;
        int unsigned     h;
        int unsigned     ic;
        int unsigned     ir;
        int unsigned     c;
        int              r;
        int              sr;
        int              sc;
        bit              drain;
        logic [7:0]      pix;
        logic [2:0][7:0] fresh;
        logic [8:0][7:0] taps;
        t_out_item       res;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        ic = in_col;
        ir = in_row;
        drain = (ir >= h);
        if (it.flush && !drain) return;
        pix   = drain ? 8'h00 : it.pixel_value;
        fresh = '0;
        if (ic < w) begin
            fresh[0]        = upper_line[ic];
            fresh[1]        = middle_line[ic];
            fresh[2]        = pix;
            upper_line[ic]  = fresh[1];
            middle_line[ic] = pix;
        end
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
            win[k][2] = fresh[k];
        end
        // first column of a line completes the window of the previous line's end
        if (ic == 0) begin
            r = int'(ir) - 2;
            c = w - 1;
        end else begin
            r = int'(ir) - 1;
            c = ic - 1;
        end
        in_col = ic + 1;
        if (!drain && in_col >= w) begin
            in_col = 0;
            in_row = ir + 1;
        end
        if (r < 0) return;
        for (int rr = 0; rr < 3; rr++) begin
            sr = ((rr == 0 && r == 0) || (rr == 2 && r == int'(h - 1))) ? 1 : rr;
            for (int cc = 0; cc < 3; cc++) begin
                sc = ((cc == 0 && c == 0) || (cc == 2 && c == w - 1)) ? 1 : cc;
                taps[rr*3+cc] = win[sr][sc];
            end
        end
        out_count          = (out_count + 1) & 32'h003F_FFFF;
        res.median_value   = median_of(taps);
        res.end_of_frame   = (out_count >= w * h);
        if (res.end_of_frame) restart_frame();
        median_q.push_back(res);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            reset_model();
            median_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (median_q.size() == 0) begin
                    $display("%0t: unexpected item: expected none, actual median %0d eof %0b",
                             $time, i_out_item.median_value, i_out_item.end_of_frame);
                    fail_total++;
                end else begin
                    want = median_q.pop_front();
                    if (i_out_item.median_value !== want.median_value) begin
                        $display("%0t: median mismatch: expected %0d, actual %0d",
                                 $time, want.median_value, i_out_item.median_value);
                        fail_total++;
                    end
                    if (i_out_item.end_of_frame !== want.end_of_frame) begin
                        $display("%0t: end_of_frame mismatch: expected %0b, actual %0b",
                                 $time, want.end_of_frame, i_out_item.end_of_frame);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data[WIDTH_W-1:0];
                    restart_frame();
                end else if (i_cfg_idx == CFG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_data[HEIGHT_W-1:0];
                    restart_frame();
                end
            end
            if (i_in_valid && !i_in_stall) predict_item(i_in_item);
        end
        o_pending    <= median_q.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: sim/tb_median_filter_3x3.sv
module tb_median_filter_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_ITEMS   = 450;
    localparam int FULL_FRAME     = 32'h7FFF_FFFF;
    localparam int MAX_HEIGHT     = 4095;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                    fail_count;
    int                    pending;
    logic [CFG_DATA_W-1:0] width_shadow  = CFG_DATA_W'(WIDTH_RESET);
    logic [CFG_DATA_W-1:0] height_shadow = HEIGHT_RESET;
    bit                    tx_quiet = 1'b0;
    bit                    rx_quiet = 1'b0;
    int                    rx_hold = 0;
    int                    idle_cycles = 0;
    int                    stim_items = 0;

    always #5 clk = ~clk;

    median_filter_3x3 uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    mf3_median_checker u_median_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if ($urandom_range(0, 149) == 0) rx_quiet = ~rx_quiet;
            if (out_valid && !out_stall) begin
                rx_hold = rx_quiet ? 0 : $urandom_range(0, 13);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end else if (!rx_quiet && $urandom_range(0, 15) == 0) begin
                rx_hold = $urandom_range(1, 13);
            end
            out_stall <= (rx_hold > 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int clamp_dim(input int v, input int hi);
        return (v < 3) ? 3 : (v > hi) ? hi : v;
    endfunction

    function automatic logic [7:0] draw_pixel(input int mode, input logic [7:0] base);
        case (mode)
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2:       return 8'(base + $urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic [7:0] pix, input logic is_flush);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= '{pixel_value: pix, flush: is_flush};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_FRAME_WIDTH) width_shadow = data;
        else height_shadow = data;
    endtask

    // cut < frame size leaves the frame unfinished; the next register write restarts it
    task automatic send_frame(input int cut);
        int         w;
        int         h;
        int         total;
        int         mode;
        logic [7:0] base;
        w     = clamp_dim(int'(width_shadow[WIDTH_W-1:0]), MAX_WIDTH);
        h     = clamp_dim(int'(height_shadow), MAX_HEIGHT);
        total = w * h;
        mode  = $urandom_range(0, 3);
        base  = 8'($urandom_range(0, 255));
        tx_quiet = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < total && n < cut; n++) begin
            if ($urandom_range(0, 11) == 0) send_item(draw_pixel(0, base), 1'b1);
            send_item(draw_pixel(mode, base), 1'b0);
            stim_items++;
            if ($urandom_range(0, 299) == 0) wait_drained();
        end
        if (cut >= total) begin
            for (int n = 0; n <= w; n++) begin
                send_item(draw_pixel(0, base), 1'($urandom_range(0, 1)));
                stim_items++;
            end
        end
    endtask

    initial begin : stimulus
        int sel;
        int w;
        int h;
        int frames;
        logic [CFG_DATA_W-1:0] wval;
        logic [CFG_DATA_W-1:0] hval;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry is 640x480: too few items for any result
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h5A, 1'b0);
        settle();

        // 3x3 frame, bit 11 of the width data is ignored
        cfg_write(CFG_FRAME_WIDTH, 12'h803);
        cfg_write(CFG_FRAME_HEIGHT, 12'd3);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        wait_drained();
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'd128, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'd77, 1'b0);
        send_item(8'hAA, 1'b1);
        send_item(8'hFF, 1'b0);
        // next frame follows the end_of_frame item directly
        for (int k = 0; k < 9; k++) send_item(8'(255 - 31 * k), 1'b0);
        repeat (4) send_item(8'h00, 1'b1);

        settle();
        cfg_write(CFG_FRAME_WIDTH, 12'hFFF);
        cfg_write(CFG_FRAME_HEIGHT, 12'd3);
        send_frame(MAX_WIDTH + 4);

        settle();
        cfg_write(CFG_FRAME_WIDTH, 12'd0);
        cfg_write(CFG_FRAME_HEIGHT, 12'hFFF);
        send_frame(40);

        settle();
        cfg_write(CFG_FRAME_WIDTH, 12'd1);
        cfg_write(CFG_FRAME_HEIGHT, 12'd2);
        send_frame(FULL_FRAME);

        settle();
        cfg_write(CFG_FRAME_HEIGHT, 12'd0);
        cfg_write(CFG_FRAME_WIDTH, 12'd2);
        send_frame(FULL_FRAME);

        stim_items = 0;
        while (stim_items < RANDOM_ITEMS) begin
            settle();
            sel = $urandom_range(0, 9);
            if (sel == 0) wval = CFG_DATA_W'($urandom_range(0, 2));
            else if (sel == 1) wval = CFG_DATA_W'($urandom_range(11, 40));
            else wval = CFG_DATA_W'($urandom_range(3, 10));
            wval[11] = 1'($urandom_range(0, 1));
            hval = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                : CFG_DATA_W'($urandom_range(3, 6));
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
                cfg_write(CFG_FRAME_WIDTH, wval);
            end else if (sel == 1) begin
                cfg_write(CFG_FRAME_HEIGHT, hval);
            end else if (sel == 2) begin
                cfg_write(CFG_FRAME_WIDTH, wval);
                cfg_write(CFG_FRAME_HEIGHT, hval);
            end else begin
                cfg_write(CFG_FRAME_HEIGHT, hval);
                cfg_write(CFG_FRAME_WIDTH, wval);
            end
            w = clamp_dim(int'(width_shadow[WIDTH_W-1:0]), MAX_WIDTH);
            h = clamp_dim(int'(height_shadow), MAX_HEIGHT);
            frames = $urandom_range(1, 3);
            repeat (frames - 1) send_frame(FULL_FRAME);
            send_frame(($urandom_range(0, 5) == 0) ? int'($urandom_range(1, w * h)) : FULL_FRAME);
        end

        settle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
